### hw/rtl/tllhp_pkg.sv
// Package for the two-level local-history branch predictor.
// Holds the sizing constants, the history-row and counter-row types and the
// command structs shared by the table modules and the top level. No dependencies.
package tllhp_pkg;

    localparam int INDEX_BITS   = 6;
    localparam int WAYS         = 4;
    localparam int HISTORY_BITS = 12;
    localparam int TAG_BITS     = 4;
    localparam int COUNTER_BITS = 2;
    localparam int ADDR_BITS    = 32;

    localparam int NUM_SETS = 1 << INDEX_BITS;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

    // The pattern table is stored as rows of several counters each.
    localparam int CTR_SEL_BITS = (HISTORY_BITS > 4) ? 4 : HISTORY_BITS - 1;
    localparam int CTR_ROW_BITS = HISTORY_BITS - CTR_SEL_BITS;
    localparam int CTR_ROWS     = 1 << CTR_ROW_BITS;
    localparam int CTRS_PER_ROW = 1 << CTR_SEL_BITS;

    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic [WAY_BITS-1:0]     rank;
        logic [TAG_BITS-1:0]     tag;
        logic [HISTORY_BITS-1:0] hist;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] hist_row_t;

    typedef logic [CTRS_PER_ROW-1:0][COUNTER_BITS-1:0] ctr_row_t;

    typedef struct packed {
        logic                  en;
        logic [INDEX_BITS-1:0] set;
        hist_row_t             row;
    } hist_wr_t;

    typedef struct packed {
        logic                    rd_en;
        logic [HISTORY_BITS-1:0] rd_hist;
        logic                    train_en;
        logic                    taken;
    } ctr_cmd_t;

    // Contents of a history row that has never been written.
    function automatic hist_row_t reset_row();
        hist_row_t r;
        for (int w = 0; w < WAYS; w++)
        begin
            r[w].valid = 1'b0;
            r[w].rank  = WAY_BITS'(w);
            r[w].tag   = '0;
            r[w].hist  = '1;
        end
        return r;
    endfunction

endpackage

### hw/rtl/tllhp_hist_table.sv
// History table: one synchronous memory row per set holding every way's tag,
// history, valid bit and recency rank. Depends on tllhp_pkg.
module tllhp_hist_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [tllhp_pkg::INDEX_BITS-1:0] rd_set,
    output tllhp_pkg::hist_row_t           rd_row,
    input  tllhp_pkg::hist_wr_t            wr
);
    import tllhp_pkg::*;

    hist_row_t             mem [NUM_SETS];
    hist_row_t             rd_data_reg;
    logic [NUM_SETS-1:0]   set_valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.set] <= wr.row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_set];
        end
    end

    // A set that was never written reads as its reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                set_valid_reg[wr.set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= set_valid_reg[rd_set];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : reset_row();

endmodule

### hw/rtl/tllhp_ctr_table.sv
// Pattern table of saturating counters in one synchronous memory, with the
// clearing pass after reset and read-modify-write training. Depends on tllhp_pkg.
module tllhp_ctr_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tllhp_pkg::ctr_cmd_t              cmd,
    output logic [tllhp_pkg::COUNTER_BITS-1:0] ctr,
    output logic                             clearing
);
    import tllhp_pkg::*;

    ctr_row_t                mem [CTR_ROWS];
    ctr_row_t                rd_row_reg;
    logic [CTR_ROW_BITS-1:0] addr_reg;
    logic [CTR_SEL_BITS-1:0] sel_reg;
    logic                    busy_reg;
    logic [CTR_ROW_BITS-1:0] clr_idx_reg;

    logic                    wr_en;
    logic [CTR_ROW_BITS-1:0] wr_addr;
    ctr_row_t                wr_row;
    logic [COUNTER_BITS-1:0] trained;

    assign ctr = rd_row_reg[sel_reg];

    always_comb
    begin
        if (cmd.taken)
        begin
            trained = (ctr == '1) ? ctr : ctr + 1'b1;
        end
        else
        begin
            trained = (ctr == '0) ? ctr : ctr - 1'b1;
        end
        wr_row = rd_row_reg;
        wr_row[sel_reg] = trained;
        wr_addr = addr_reg;
        wr_en = cmd.train_en;
        if (busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_row  = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg <= mem[cmd.rd_hist[HISTORY_BITS-1:CTR_SEL_BITS]];
            addr_reg   <= cmd.rd_hist[HISTORY_BITS-1:CTR_SEL_BITS];
            sel_reg    <= cmd.rd_hist[CTR_SEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == '1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign clearing = busy_reg;

endmodule

### hw/rtl/tllhp_way_logic.sv
// Way selection and row update for one history row: tag match, victim choice,
// recency touch and history shift. Combinational. Depends on tllhp_pkg.
module tllhp_way_logic (
    input  tllhp_pkg::hist_row_t               row,
    input  logic [tllhp_pkg::TAG_BITS-1:0]     tag,
    input  logic                               is_update,
    input  logic                               is_cond,
    input  logic                               taken,
    output logic                               hit,
    output logic [tllhp_pkg::HISTORY_BITS-1:0] hist_sel,
    output logic                               wr_en,
    output tllhp_pkg::hist_row_t               new_row
);
    import tllhp_pkg::*;

    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] free_way;
    logic [WAY_BITS-1:0] lru_way;
    logic [WAY_BITS-1:0] tgt;
    logic [WAY_BITS-1:0] old_rank;
    logic                free_found;

    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        lru_way    = '0;
        // Descending scans leave the lowest-numbered qualifying way.
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row[w].valid && row[w].tag == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!row[w].valid)
            begin
                free_found = 1'b1;
                free_way   = WAY_BITS'(w);
            end
            if (row[w].rank == '0)
            begin
                lru_way = WAY_BITS'(w);
            end
        end

        if (hit)
        begin
            tgt = hit_way;
        end
        else if (free_found)
        begin
            tgt = free_way;
        end
        else
        begin
            tgt = lru_way;
        end

        old_rank = row[tgt].rank;
        new_row  = row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row[w].rank > old_rank)
            begin
                new_row[w].rank = row[w].rank - 1'b1;
            end
        end
        new_row[tgt].rank = WAY_BITS'(WAYS - 1);

        if (is_update)
        begin
            if (hit)
            begin
                new_row[tgt].hist = {row[tgt].hist[HISTORY_BITS-2:0], taken};
            end
            else
            begin
                new_row[tgt].valid = 1'b1;
                new_row[tgt].tag   = tag;
                new_row[tgt].hist  = '1;
            end
        end

        hist_sel = hit ? row[hit_way].hist : '1;
        wr_en    = is_update ? is_cond : hit;
    end

endmodule

### hw/rtl/two_level_local_history_predictor.sv
// Top level of the two-level local-history branch predictor.
// Instantiates tllhp_hist_table, tllhp_ctr_table and tllhp_way_logic; uses tllhp_pkg.
//
// This block takes predict and update requests for branch addresses. Address
// bits above the low two give the set index and then the tag; the set row of the
// history table holds, for each way, a tag, a local history, a valid bit and a
// recency rank. A hit's history addresses the shared table of saturating
// counters; a miss uses the counter at the all-ones history. A predict request
// returns one result (pred_taken, table_hit) and makes a hit way most recent.
// An update request for a conditional branch trains the counter, shifts the
// outcome into the history and touches the way on a hit, or allocates the first
// invalid way (else the least recent) with an all-ones history on a miss; it
// returns no result, and an update for a non-conditional branch does nothing.
// Each request reads the history row, then the counter row that its history
// selects, both from synchronous memories with registered read data, so a new
// request is accepted only once the previous one finishes. The history row is
// written back in state S_HIST and the counter row in state S_CTR, before the
// next request can read either. After reset the block runs a clearing pass over
// all 256 counter rows (one counter row a cycle) that sets every counter to its
// maximum, and it accepts no request until that is done. A finished result
// waits in an output register; a new request is accepted while it waits, and a
// predict request stalls in state S_CTR only if the previous result has still
// not been taken.
module two_level_local_history_predictor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [tllhp_pkg::ADDR_BITS-1:0]  branch_addr,
    input  logic                             taken,
    input  logic                             is_cond_branch,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pred_taken,
    output logic                             table_hit
);
    import tllhp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HIST  = 4'b0100,
        S_CTR   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Fields of the request at work, captured when it is accepted.
    logic                  req_type_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [INDEX_BITS-1:0] set_reg;
    logic                  taken_reg;
    logic                  cond_reg;
    logic                  hit_reg;

    logic out_valid_reg;
    logic pred_taken_reg;
    logic table_hit_reg;

    logic                    accept;
    logic                    finish_ok;
    logic                    finish;
    logic                    clearing;
    hist_row_t               rd_row;
    hist_wr_t                hist_wr;
    ctr_cmd_t                ctr_cmd;
    logic [COUNTER_BITS-1:0] ctr;
    logic                    wl_hit;
    logic [HISTORY_BITS-1:0] wl_hist_sel;
    logic                    wl_wr_en;
    hist_row_t               wl_new_row;

    // A predict request can only finish once the output register is free.
    assign finish_ok = (req_type_reg == REQ_UPDATE) || !out_valid_reg || out_ready;
    assign finish    = (state_reg == S_CTR) && finish_ok;
    assign in_ready  = (state_reg == S_IDLE) || finish;
    assign accept    = in_valid && in_ready;

    tllhp_hist_table u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_set (branch_addr[INDEX_BITS+1:2]),
        .rd_row (rd_row),
        .wr     (hist_wr)
    );

    tllhp_way_logic u_way (
        .row       (rd_row),
        .tag       (tag_reg),
        .is_update (req_type_reg == REQ_UPDATE),
        .is_cond   (cond_reg),
        .taken     (taken_reg),
        .hit       (wl_hit),
        .hist_sel  (wl_hist_sel),
        .wr_en     (wl_wr_en),
        .new_row   (wl_new_row)
    );

    tllhp_ctr_table u_ctr (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ctr_cmd),
        .ctr      (ctr),
        .clearing (clearing)
    );

    // The history row goes back in the cycle its read data arrives; the counter
    // row is trained only when an update hit finishes.
    always_comb
    begin
        hist_wr.en  = (state_reg == S_HIST) && wl_wr_en;
        hist_wr.set = set_reg;
        hist_wr.row = wl_new_row;

        ctr_cmd.rd_en    = (state_reg == S_HIST);
        ctr_cmd.rd_hist  = wl_hist_sel;
        ctr_cmd.train_en = finish && (req_type_reg == REQ_UPDATE) && cond_reg && hit_reg;
        ctr_cmd.taken    = taken_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HIST;
                end
            end
            S_HIST:
            begin
                state_next = S_CTR;
            end
            S_CTR:
            begin
                if (finish)
                begin
                    state_next = accept ? S_HIST : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish && req_type_reg == REQ_PREDICT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req_type;
            set_reg      <= branch_addr[INDEX_BITS+1:2];
            tag_reg      <= branch_addr[INDEX_BITS+TAG_BITS+1:INDEX_BITS+2];
            taken_reg    <= taken;
            cond_reg     <= is_cond_branch;
        end
        if (state_reg == S_HIST)
        begin
            hit_reg <= wl_hit;
        end
        if (finish && req_type_reg == REQ_PREDICT)
        begin
            pred_taken_reg <= ctr[COUNTER_BITS-1];
            table_hit_reg  <= hit_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pred_taken = pred_taken_reg;
    assign table_hit  = table_hit_reg;

`ifndef SYNTHESIS
    // No request may enter while the counter table is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("request accepted during clearing pass");

    // A new result only appears when a predict request finishes its counter read.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_CTR && req_type_reg == REQ_PREDICT))
        else $error("result produced outside a finishing predict request");

    // An accepted request always reads its history row in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_HIST))
        else $error("accepted request did not start its history read");

    // Counter training never overlaps the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctr_cmd.train_en |-> !clearing)
        else $error("counter trained during clearing pass");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_level_local_history_predictor: directed and random
// predict/update requests, each prediction checked against a behavioral model kept here.
// Depends only on tllhp_pkg and the predictor RTL.
module tb;

    import tllhp_pkg::*;

    localparam int ENTRIES   = NUM_SETS * WAYS;
    localparam int PATTERNS  = 1 << HISTORY_BITS;
    localparam int POOL_SIZE = 16;
    localparam int ITEMS     = 600;

    // Behavioral copy of the predictor. Every accepted request advances the
    // tables in acceptance order, and every predict request leaves one
    // expected outcome behind in pending_predictions.
    class branch_board;

        typedef struct {
            logic pred;
            logic hit;
        } outcome_t;

        outcome_t                pending_predictions[$];
        logic [TAG_BITS-1:0]     tags [ENTRIES];
        logic [HISTORY_BITS-1:0] hists [ENTRIES];
        logic                    valids [ENTRIES];
        logic [WAY_BITS-1:0]     ranks [ENTRIES];
        logic [COUNTER_BITS-1:0] counters [PATTERNS];
        int errors;
        int predicts;
        int hits;
        int trainings;
        int allocs;
        int evictions;
        int ignored;
        int checked;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                tags[i]   = '0;
                hists[i]  = '1;
                valids[i] = 1'b0;
                ranks[i]  = WAY_BITS'(i % WAYS);
            end
            for (int i = 0; i < PATTERNS; i++)
                counters[i] = '1;
        endfunction

        // Returns the matching way of the set, or WAYS on a miss.
        function int find_way(int base, logic [TAG_BITS-1:0] t);
            for (int w = 0; w < WAYS; w++)
                if (valids[base + w] && tags[base + w] == t)
                    return w;
            return WAYS;
        endfunction

        // Moves one way to the most recent position and closes the gap it leaves.
        function void touch(int base, int way);
            logic [WAY_BITS-1:0] old;
            old = ranks[base + way];
            for (int w = 0; w < WAYS; w++)
                if (ranks[base + w] > old)
                    ranks[base + w] = ranks[base + w] - 1'b1;
            ranks[base + way] = WAY_BITS'(WAYS - 1);
        endfunction

        function void note_request(logic rt, logic [ADDR_BITS-1:0] addr, logic tk,
                                   logic cond);
            logic [INDEX_BITS-1:0]   set;
            logic [TAG_BITS-1:0]     t;
            logic [HISTORY_BITS-1:0] h;
            logic [COUNTER_BITS-1:0] c;
            outcome_t                o;
            int                      base;
            int                      way;
            int                      victim;
            set  = addr[INDEX_BITS+1:2];
            t    = addr[INDEX_BITS+2 +: TAG_BITS];
            base = int'(set) * WAYS;
            way  = find_way(base, t);
            if (rt == REQ_PREDICT)
            begin
                h = '1;
                if (way < WAYS)
                begin
                    h = hists[base + way];
                    touch(base, way);
                    hits++;
                end
                o.pred = counters[h][COUNTER_BITS-1];
                o.hit  = (way < WAYS);
                pending_predictions.push_back(o);
                predicts++;
                return;
            end
            if (!cond)
            begin
                ignored++;
                return;
            end
            if (way < WAYS)
            begin
                // Train the selected counter, then shift the outcome into the history.
                h = hists[base + way];
                c = counters[h];
                if (tk && c != {COUNTER_BITS{1'b1}})
                    c = c + 1'b1;
                else if (!tk && c != '0)
                    c = c - 1'b1;
                counters[h]       = c;
                hists[base + way] = {h[HISTORY_BITS-2:0], tk};
                touch(base, way);
                trainings++;
            end
            else
            begin
                victim = WAYS;
                for (int w = 0; w < WAYS && victim == WAYS; w++)
                    if (!valids[base + w])
                        victim = w;
                if (victim == WAYS)
                begin
                    victim = 0;
                    for (int w = WAYS - 1; w >= 0; w--)
                        if (ranks[base + w] == '0)
                            victim = w;
                    evictions++;
                end
                valids[base + victim] = 1'b1;
                tags[base + victim]   = t;
                hists[base + victim]  = '1;
                touch(base, victim);
                allocs++;
            end
        endfunction

        task report_mismatch(string what);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic pred, logic hit);
            outcome_t o;
            if (pending_predictions.size() == 0)
            begin
                report_mismatch($sformatf("result pred=%b hit=%b with no prediction due",
                                          pred, hit));
                return;
            end
            o = pending_predictions.pop_front();
            checked++;
            if (pred !== o.pred)
                report_mismatch($sformatf("pred_taken %b, expected %b (prediction %0d)",
                                          pred, o.pred, checked));
            if (hit !== o.hit)
                report_mismatch($sformatf("table_hit %b, expected %b (prediction %0d)",
                                          hit, o.hit, checked));
        endtask

    endclass

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic                 req_type       = REQ_PREDICT;
    logic [ADDR_BITS-1:0] branch_addr    = '0;
    logic                 taken          = 1'b0;
    logic                 is_cond_branch = 1'b0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic                 pred_taken;
    logic                 table_hit;

    branch_board board;

    // When set, neither side inserts idle cycles, so requests run back to back.
    bit quiet = 1'b0;

    // A small working set of branches keeps the sets crowded, so hits, evictions
    // and long trained histories all show up. Each branch has its own taken bias.
    logic [ADDR_BITS-1:0] pool_addr [POOL_SIZE];
    int                   pool_bias [POOL_SIZE];

    two_level_local_history_predictor i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .branch_addr    (branch_addr),
        .taken          (taken),
        .is_cond_branch (is_cond_branch),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pred_taken     (pred_taken),
        .table_hit      (table_hit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Requests go into the model at the edge where they are accepted; the values
    // read here are the ones present just before that edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready === 1'b1)
            board.note_request(req_type, branch_addr, taken, is_cond_branch);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            board.check_result(pred_taken, table_hit);
    end

    // Random address with the given set and tag; low bits and upper bits are noise.
    function automatic logic [ADDR_BITS-1:0] make_addr(int set, int tg);
        logic [ADDR_BITS-1:0] a;
        a = $urandom();
        a[INDEX_BITS+1:2]           = INDEX_BITS'(set);
        a[INDEX_BITS+2 +: TAG_BITS] = TAG_BITS'(tg);
        return a;
    endfunction

    // Holds one request on the input until it is accepted. The idle gap comes
    // first; with no gap valid simply stays high for the next request.
    task automatic send_request(logic rt, logic [ADDR_BITS-1:0] addr, logic tk, logic cond);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= rt;
        branch_addr    <= addr;
        taken          <= tk;
        is_cond_branch <= cond;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    task automatic build_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            // Only a few sets are used, so the four ways of a set fill up quickly.
            pool_addr[i] = make_addr($urandom_range(0, 3), $urandom_range(0, (1 << TAG_BITS) - 1));
            pool_bias[i] = 25 * $urandom_range(0, 4);
        end
    endtask

    // Result side: a fresh stall is drawn for every result taken.
    initial
    begin
        int stall;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid === 1'b1 && out_ready));
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: requests or results stopped moving");
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int                   counted;
        int                   pick;
        int                   drain;
        logic                 rt;
        logic                 tk;
        logic                 cond;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] far_addr;

        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block runs its counter-clearing pass first; the
        // driver just waits for in_ready to come up.
        far_addr = '1;
        // Predictions on an empty table miss and read the all-ones counter;
        // taken on a predict request has no effect.
        send_request(REQ_PREDICT, '0, 1'b1, 1'b1);
        send_request(REQ_PREDICT, far_addr, 1'b0, 1'b0);
        // An update for a non-conditional branch changes nothing.
        send_request(REQ_UPDATE, far_addr, 1'b1, 1'b0);
        send_request(REQ_PREDICT, far_addr, 1'b0, 1'b0);
        // Allocation, then training: a taken outcome saturates at the top,
        // not-taken outcomes walk the counters and the history down.
        send_request(REQ_UPDATE, far_addr, 1'b1, 1'b1);
        send_request(REQ_PREDICT, far_addr, 1'b0, 1'b1);
        send_request(REQ_UPDATE, far_addr, 1'b1, 1'b1);
        send_request(REQ_UPDATE, far_addr, 1'b0, 1'b1);
        send_request(REQ_UPDATE, far_addr, 1'b0, 1'b1);
        send_request(REQ_PREDICT, far_addr, 1'b1, 1'b0);
        // Five branches in one set: four fill the ways, the fifth evicts the
        // least recent one.
        for (int t = 0; t < 5; t++)
            send_request(REQ_UPDATE, make_addr(0, t), 1'b0, 1'b1);
        send_request(REQ_PREDICT, make_addr(0, 0), 1'b0, 1'b0);
        send_request(REQ_PREDICT, make_addr(0, 1), 1'b0, 1'b0);
        // A predict hit reorders the set, so the next eviction picks another way.
        send_request(REQ_UPDATE, make_addr(0, 5), 1'b1, 1'b1);
        send_request(REQ_PREDICT, make_addr(0, 2), 1'b0, 1'b1);
        send_request(REQ_PREDICT, make_addr(0, 1), 1'b0, 1'b1);
        send_request(REQ_PREDICT, make_addr(0, 5), 1'b0, 1'b0);
        send_request(REQ_UPDATE, '0, 1'b0, 1'b1);
        send_request(REQ_PREDICT, '0, 1'b0, 1'b0);

        // Random part: mostly the working set, trained by its biases, with some
        // fully random addresses and some ignored updates mixed in.
        counted = 0;
        while (counted < ITEMS)
        begin
            if (counted % 150 == 0)
                build_pool();
            if (counted % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 99) < 15)
            begin
                addr = $urandom();
                tk   = 1'($urandom_range(0, 1));
            end
            else
            begin
                addr = pool_addr[pick];
                addr[1:0] = 2'($urandom_range(0, 3));
                addr[ADDR_BITS-1:INDEX_BITS+2+TAG_BITS] =
                    (ADDR_BITS-INDEX_BITS-2-TAG_BITS)'($urandom());
                tk = ($urandom_range(0, 99) < pool_bias[pick]);
            end
            rt   = ($urandom_range(0, 99) < 45) ? REQ_PREDICT : REQ_UPDATE;
            cond = ($urandom_range(0, 99) < 90);
            send_request(rt, addr, tk, cond);
            if (rt == REQ_PREDICT || cond)
                counted++;
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // Drain the outstanding predictions, then give a trailing request a few
        // cycles to show any stray result.
        drain = 0;
        while (board.pending_predictions.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (board.pending_predictions.size() != 0)
            board.report_mismatch($sformatf("%0d predictions never returned",
                                            board.pending_predictions.size()));

        $display("covered %0d predictions (%0d hits), %0d trainings, %0d allocations",
                 board.predicts, board.hits, board.trainings, board.allocs);
        $display("%0d evictions, %0d ignored updates, %0d results checked, %0d mismatches",
                 board.evictions, board.ignored, board.checked, board.errors);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
